[rtl/ors_pkg.sv]
`timescale 1ns / 1ps

package ors_pkg;

   localparam int MAX_DEVICES = 8;
   localparam int CNT_W       = 4;
   localparam int POS_W       = 7;
   localparam int ROM_W       = 64;

   localparam logic [7:0]       FAMILY_RESET = 8'h28;
   localparam logic [7:0]       CRC_POLY     = 8'h8C;
   localparam logic [POS_W-1:0] END_POS      = 7'd65;
   localparam logic [POS_W-1:0] LAST_POS     = 7'd64;
   localparam logic [POS_W-1:0] CRC_BITS     = 7'd56;
   localparam logic [POS_W-1:0] FIRST_POS    = 7'd1;

   typedef enum logic [1:0] {
      FN_RESTART = 2'd0,
      FN_PASS    = 2'd1,
      FN_BIT     = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FOUND   = 3'd1,
      ST_NO_RESP = 3'd2,
      ST_DONE    = 3'd3,
      ST_NO_PRES = 3'd4,
      ST_FULL    = 3'd5,
      ST_IGNORED = 3'd6
   } status_type;

   typedef struct packed {
      logic [ROM_W-1:0] rom_bits;
      logic [POS_W-1:0] discrepancy_pos;
      logic [POS_W-1:0] last_zero_pos;
      logic [POS_W-1:0] bit_position;
      logic             search_finished;
      logic             pass_active;
      logic [7:0]       crc_accum;
      logic [CNT_W-1:0] accepted_count;
   } search_state_type;

   typedef struct packed {
      logic [1:0] func;
      logic       presence;
      logic       id_bit;
      logic       complement_bit;
   } req_item_type;

   typedef struct packed {
      logic             direction;
      status_type       status;
      logic [ROM_W-1:0] rom_code;
      logic             crc_ok;
      logic             family_ok;
      logic             last_device;
      logic [CNT_W-1:0] device_count;
   } rsp_item_type;

   localparam search_state_type STATE_CLEAR = '{
      rom_bits:        '0,
      discrepancy_pos: '0,
      last_zero_pos:   '0,
      bit_position:    FIRST_POS,
      search_finished: 1'b0,
      pass_active:     1'b0,
      crc_accum:       '0,
      accepted_count:  '0
   };

   // one step of the reflected CRC-8
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic din);
      logic [7:0] sh;
      sh = {1'b0, crc[7:1]};
      if (crc[0] ^ din) begin
         sh = sh ^ CRC_POLY;
      end
      return sh;
   endfunction

endpackage

[rtl/ors_step.sv]
`timescale 1ns / 1ps

module ors_step (
   input  ors_pkg::search_state_type cur,
   input  ors_pkg::req_item_type     item,
   input  logic [7:0]                family_code,
   output ors_pkg::search_state_type nxt,
   output ors_pkg::rsp_item_type     rsp
);

   logic [5:0]                bit_idx;
   logic                      dir;
   logic                      in_range;
   logic [ors_pkg::ROM_W-1:0] rom_new;
   logic [7:0]                crc_new;
   logic                      crc_ok;
   logic                      fam_ok;

   assign bit_idx  = 6'(cur.bit_position - ors_pkg::FIRST_POS);
   assign in_range = (cur.bit_position >= ors_pkg::FIRST_POS)
                     && (cur.bit_position < ors_pkg::END_POS);

   // direction choice: forced by the bus, else follow the previous path below the last discrepancy, 1 at it, 0 beyond
   always_comb begin
      if (item.id_bit != item.complement_bit) begin
         dir = item.id_bit;
      end else if (cur.bit_position < cur.discrepancy_pos) begin
         dir = cur.rom_bits[bit_idx];
      end else begin
         dir = (cur.bit_position == cur.discrepancy_pos);
      end
   end

   always_comb begin
      rom_new          = cur.rom_bits;
      rom_new[bit_idx] = dir;
   end

   assign crc_new = (cur.bit_position <= ors_pkg::CRC_BITS)
                    ? ors_pkg::crc8_step(cur.crc_accum, dir) : cur.crc_accum;
   assign crc_ok  = (crc_new == rom_new[63:56]);
   assign fam_ok  = (rom_new[7:0] == family_code);

   always_comb begin
      nxt              = cur;
      rsp.direction    = 1'b0;
      rsp.status       = ors_pkg::ST_OK;
      rsp.rom_code     = '0;
      rsp.crc_ok       = 1'b0;
      rsp.family_ok    = 1'b0;
      case (item.func)
         ors_pkg::FN_RESTART: begin
            nxt = ors_pkg::STATE_CLEAR;
         end
         ors_pkg::FN_PASS: begin
            if (cur.accepted_count >= ors_pkg::CNT_W'(ors_pkg::MAX_DEVICES)) begin
               nxt.pass_active = 1'b0;
               rsp.status      = ors_pkg::ST_FULL;
            end else if (cur.search_finished) begin
               nxt.pass_active = 1'b0;
               rsp.status      = ors_pkg::ST_DONE;
            end else if (!item.presence) begin
               nxt.discrepancy_pos = '0;
               nxt.search_finished = 1'b0;
               nxt.pass_active     = 1'b0;
               rsp.status          = ors_pkg::ST_NO_PRES;
            end else begin
               nxt.pass_active   = 1'b1;
               nxt.bit_position  = ors_pkg::FIRST_POS;
               nxt.last_zero_pos = '0;
               nxt.crc_accum     = '0;
            end
         end
         ors_pkg::FN_BIT: begin
            if (!(cur.pass_active && in_range)) begin
               rsp.status = ors_pkg::ST_IGNORED;
            end else if (item.id_bit && item.complement_bit) begin
               nxt.pass_active = 1'b0;
               rsp.status      = ors_pkg::ST_NO_RESP;
            end else begin
               rsp.direction    = dir;
               nxt.rom_bits     = rom_new;
               nxt.crc_accum    = crc_new;
               nxt.bit_position = cur.bit_position + 7'd1;
               if ((item.id_bit == item.complement_bit) && !dir) begin
                  nxt.last_zero_pos = cur.bit_position;
               end
               if (cur.bit_position == ors_pkg::LAST_POS) begin
                  nxt.pass_active     = 1'b0;
                  nxt.discrepancy_pos = nxt.last_zero_pos;
                  if (nxt.last_zero_pos == '0) begin
                     nxt.search_finished = 1'b1;
                  end
                  if (crc_ok && fam_ok
                      && (cur.accepted_count < ors_pkg::CNT_W'(ors_pkg::MAX_DEVICES))) begin
                     nxt.accepted_count = cur.accepted_count + 4'd1;
                  end
                  rsp.crc_ok    = crc_ok;
                  rsp.family_ok = fam_ok;
                  rsp.rom_code  = rom_new;
                  rsp.status    = ors_pkg::ST_FOUND;
               end
            end
         end
         default: begin
            rsp.status = ors_pkg::ST_IGNORED;
         end
      endcase
      rsp.last_device  = nxt.search_finished;
      rsp.device_count = nxt.accepted_count;
   end

endmodule

[rtl/onewire_rom_search_engine_core.sv]
`timescale 1ns / 1ps
// channel   direction  words carried
// req_*     in         restart / pass start / bit pair
// rsp_*     out        one result word per request word
// csr_*     in         family code register write
//
// One request word per cycle while rsp_tready is high: each word is held in
// the input register, the search step runs between it and the result
// register, which drives rsp_tvalid.
// A stalled rsp_tready holds the result register; the input register still
// takes one more word, then req_tready drops.
// Reset (synchronous) clears the search state and loads family code 0x28.

module onewire_rom_search_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // presence, id_bit, complement_bit, zero pad
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // direction, rom_code[64], crc_ok, family_ok,
                                   // last_device, device_count[4]
   output logic [2:0]  rsp_tuser,  // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic                      csr_write;
   logic [7:0]                family_code_ff;
   logic                      in_valid_ff;
   ors_pkg::req_item_type     in_item_ff;
   ors_pkg::search_state_type state_ff;
   ors_pkg::search_state_type state_in;
   logic                      out_valid_ff;
   ors_pkg::rsp_item_type     out_item_ff;
   ors_pkg::rsp_item_type     out_item_in;
   logic                      out_free;
   logic                      step_go;

   assign csr_write  = csr_valid;
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_go    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         family_code_ff <= ors_pkg::FAMILY_RESET;
      end else if (csr_write) begin
         family_code_ff <= csr_data;
      end
   end

   ors_step u_step (
      .cur         (state_ff),
      .item        (in_item_ff),
      .family_code (family_code_ff),
      .nxt         (state_in),
      .rsp         (out_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ors_pkg::STATE_CLEAR;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.func           <= req_tuser;
         in_item_ff.presence       <= req_tdata[0];
         in_item_ff.id_bit         <= req_tdata[1];
         in_item_ff.complement_bit <= req_tdata[2];
      end
      if (step_go) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.status;
   assign rsp_tdata  = {out_item_ff.device_count, out_item_ff.last_device,
                        out_item_ff.family_ok, out_item_ff.crc_ok,
                        out_item_ff.rom_code, out_item_ff.direction};

endmodule
